FILE: sv/efu_pkg.sv
// ----------------------------------------------------------------------------
// efu_pkg - shared constants for the encoder feedback unwrap block
// Frame layout, field widths and the wrap and total sizes used by the
// channel interfaces and the core.
// ----------------------------------------------------------------------------
package efu_pkg;

    // Encoder counts in one mechanical turn
    localparam int COUNTS_PER_TURN = 8192;

    // Width of the signed multi-turn total
    localparam int TOTAL_WIDTH = 40;

    // Frame and field widths
    localparam int FRAME_W = 64;
    localparam int WORD16_W = 16;
    localparam int TEMP_W = 8;
    localparam int STEP_W = 17;

    // Step candidates need one bit more than the chosen step
    localparam int CAND_W = STEP_W + 1;

    // Bit positions of the fields in the big-endian frame
    localparam int POS_LSB = 48;
    localparam int SPD_LSB = 32;
    localparam int CUR_LSB = 16;
    localparam int TEMP_LSB = 8;

endpackage

FILE: sv/efu_if.sv
// ----------------------------------------------------------------------------
// efu_if - valid/ready channels of the encoder feedback unwrap block
// efu_frame_if carries one feedback frame word, efu_result_if one
// unpacked and unwrapped result word.
// ----------------------------------------------------------------------------
interface efu_frame_if;
    logic                              valid;
    logic                              ready;
    logic [efu_pkg::FRAME_W-1:0]       frame_data;
    logic                              restart;

    modport source (output valid, output frame_data, output restart, input ready);
    modport sink   (input valid, input frame_data, input restart, output ready);
endinterface

interface efu_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [efu_pkg::WORD16_W-1:0]          encoder_position;
    logic [efu_pkg::WORD16_W-1:0]          speed_raw;
    logic [efu_pkg::WORD16_W-1:0]          current_raw;
    logic [efu_pkg::TEMP_W-1:0]            temperature;
    logic signed [efu_pkg::STEP_W-1:0]     step_counts;
    logic signed [efu_pkg::TOTAL_WIDTH-1:0] total_counts;

    modport source (output valid, output encoder_position, output speed_raw,
                    output current_raw, output temperature, output step_counts,
                    output total_counts, input ready);
    modport sink   (input valid, input encoder_position, input speed_raw,
                    input current_raw, input temperature, input step_counts,
                    input total_counts, output ready);
endinterface

FILE: sv/encoder_feedback_unwrap_core.sv
// ----------------------------------------------------------------------------
// encoder_feedback_unwrap_core - multi-turn unwrap of motor feedback frames
// Unpacks position, speed, current and temperature from an 8-byte frame,
// picks the shortest step across the turn wrap and keeps a saturating
// multi-turn total in encoder counts.
// ----------------------------------------------------------------------------
// Usage:
//   frame  : sink channel, one word per feedback frame (frame_data, restart).
//            A word is taken when valid and ready are both high.
//   result : source channel, one word per frame: the four raw fields, the
//            signed step chosen this frame and the total after the step.
//   Path: a frame taken passes the input register, then the result register
//   (two register stages) before it is shown on result.
//   Throughput: one frame per cycle while result is ready. The limit is the step and
//   total update, which reads and writes the previous position and total
//   in the same cycle a word moves into the result register.
//   restart = 1 zeroes the total before this frame's step is added.
//   Reset: both stages empty, previous position and total cleared to zero,
//   so the first step is taken against position zero.
//   Stall: while result is held, the input register still takes one word;
//   frame ready then drops until the result moves on. No word is lost.
// ----------------------------------------------------------------------------
module encoder_feedback_unwrap_core
(
    input  logic               clk,
    input  logic               rst_n,
    efu_frame_if.sink          frame,
    efu_result_if.source       result
);

    localparam int TW = efu_pkg::TOTAL_WIDTH;
    localparam int SW = efu_pkg::STEP_W;
    localparam int CW = efu_pkg::CAND_W;
    localparam int HW = efu_pkg::WORD16_W;

    localparam logic signed [CW-1:0] TURN_S = CW'(efu_pkg::COUNTS_PER_TURN);
    localparam logic signed [TW-1:0] TOTAL_MAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] TOTAL_MIN = {1'b1, {(TW-1){1'b0}}};

    // Input stage
    logic                          s1_valid_reg;
    logic [efu_pkg::FRAME_W-1:0]   s1_frame_reg;
    logic                          s1_restart_reg;

    // Unwrap state
    logic [HW-1:0]                 prev_pos_reg;
    logic signed [TW-1:0]          total_reg;
    logic signed [TW-1:0]          total_next;

    // Result stage
    logic                          out_valid_reg;
    logic [HW-1:0]                 pos_reg;
    logic [HW-1:0]                 spd_reg;
    logic [HW-1:0]                 cur_reg;
    logic [efu_pkg::TEMP_W-1:0]    temp_reg;
    logic signed [SW-1:0]          step_reg;

    logic                          s2_adv;
    logic                          s1_load;

    logic [HW-1:0]                 pos;
    logic signed [SW-1:0]          plain;
    logic signed [CW-1:0]          plain_x;
    logic signed [CW-1:0]          other;
    logic [CW-1:0]                 mag_plain;
    logic [CW-1:0]                 mag_other;
    logic signed [SW-1:0]          step;
    logic signed [TW-1:0]          base;
    logic signed [TW:0]            sum;

    // Handshake: move the input word on when the result register frees up
    assign s2_adv = s1_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready = !s1_valid_reg || s2_adv;
    assign s1_load = frame.valid && frame.ready;

    // Pick the shortest step across the wrap; a tie keeps the plain difference
    assign pos = s1_frame_reg[efu_pkg::POS_LSB +: HW];
    assign plain = $signed({1'b0, pos}) - $signed({1'b0, prev_pos_reg});
    assign plain_x = {plain[SW-1], plain};
    assign other = (pos < prev_pos_reg) ? (plain_x + TURN_S) : (plain_x - TURN_S);
    assign mag_plain = plain_x[CW-1] ? CW'(-plain_x) : CW'(plain_x);
    assign mag_other = other[CW-1] ? CW'(-other) : CW'(other);
    assign step = (mag_other < mag_plain) ? other[SW-1:0] : plain;

    // Add the step to the total, saturating at the signed bounds
    assign base = s1_restart_reg ? '0 : total_reg;
    assign sum = {base[TW-1], base} + {{(TW + 1 - SW){step[SW-1]}}, step};

    always_comb
    begin
        if (sum[TW] != sum[TW-1])
        begin
            total_next = sum[TW] ? TOTAL_MIN : TOTAL_MAX;
        end
        else
        begin
            total_next = sum[TW-1:0];
        end
    end

    // Hold the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            s1_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_frame_reg   <= frame.frame_data;
            s1_restart_reg <= frame.restart;
        end
    end

    // Advance state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_pos_reg  <= '0;
            total_reg     <= '0;
        end
        else
        begin
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
                prev_pos_reg  <= pos;
                total_reg     <= total_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            pos_reg  <= pos;
            spd_reg  <= s1_frame_reg[efu_pkg::SPD_LSB +: HW];
            cur_reg  <= s1_frame_reg[efu_pkg::CUR_LSB +: HW];
            temp_reg <= s1_frame_reg[efu_pkg::TEMP_LSB +: efu_pkg::TEMP_W];
            step_reg <= step;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.encoder_position = pos_reg;
    assign result.speed_raw        = spd_reg;
    assign result.current_raw      = cur_reg;
    assign result.temperature      = temp_reg;
    assign result.step_counts      = step_reg;
    assign result.total_counts     = total_reg;

    // The shown position is the one the next step is measured from
    a_prev_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (prev_pos_reg == pos_reg))
        else $error("previous position differs from shown position");

    // After a restart the total is exactly this frame's step
    a_restart_total: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && s1_restart_reg) |=>
            (total_reg == {{(TW - SW){step_reg[SW-1]}}, step_reg}))
        else $error("restart total does not equal step");

    // An empty input stage always takes a word
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> frame.ready)
        else $error("input stage empty but not ready");

endmodule
